// ----- rtl/im2col_address_generator_macros.svh -----
`ifndef IM2COL_ADDRESS_GENERATOR_MACROS_SVH
`define IM2COL_ADDRESS_GENERATOR_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define IAG_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("im2col address generator check failed");

// Antecedent implies consequent, checked at every clock edge out of reset.
`define IAG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("im2col address generator check failed");

`endif

// ----- rtl/im2col_ag_pkg.sv -----
package im2col_ag_pkg;

  localparam int unsigned SizeBitsDefault = 12;

  localparam int unsigned ChanW    = 12;
  localparam int unsigned KerW     = 8;
  localparam int unsigned PosW     = 12;
  localparam int unsigned SizeRegW = 13;
  localparam int unsigned LaneW    = 8;
  localparam int unsigned SetW     = 3 * LaneW;
  localparam int unsigned AddrW    = 48;
  localparam int unsigned HalfW    = AddrW / 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = SetW;

  localparam int unsigned IagLatency = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChannelsLast = 3'd0,
    CfgInChannels   = 3'd1,
    CfgInDepth      = 3'd2,
    CfgInHeight     = 3'd3,
    CfgInWidth      = 3'd4,
    CfgStride       = 3'd5,
    CfgDilation     = 3'd6,
    CfgPadding      = 3'd7
  } cfg_idx_e;

endpackage

// ----- rtl/im2col_address_generator.sv -----
// im2col address generator for 3D convolution with stride, dilation and
// zero padding.
// Input channel: an item (channel, kernel offset, output position) is taken
// at each rising edge with start_i high and busy_o low. busy_o stays low, so
// one item per cycle is taken without a gap.
// Result channel: done_o marks one cycle with inside_res_o and
// src_address_o; inside_res_o low means zero padding and the address is 0.
// From the accepting edge to the done_o cycle an item passes the address
// chain: coordinate products, coordinate check, then three dependent
// multiply-add steps, the last split into two half-width partial products.
// Throughput is one result per cycle; the receiver cannot stall, and results
// leave in the order items arrived.
// Configuration: cfg_we_i writes register cfg_index_i at once; write only
// while no item is in flight. Size registers above 2^SIZE_BITS are clamped.
// Reset clears the pipeline valid bits and loads the default registers:
// channels first, all sizes 1, strides and dilations 1, no padding.
module im2col_address_generator
  import im2col_ag_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SizeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [ChanW-1:0]    channel_i,
  input  logic [KerW-1:0]     kernel_d_i,
  input  logic [KerW-1:0]     kernel_h_i,
  input  logic [KerW-1:0]     kernel_w_i,
  input  logic [PosW-1:0]     out_d_i,
  input  logic [PosW-1:0]     out_h_i,
  input  logic [PosW-1:0]     out_w_i,
  output logic                done_o,
  output logic                inside_res_o,
  output logic [AddrW-1:0]    src_address_o
);

  localparam int unsigned SZW      = SIZE_BITS + 1;
  localparam int unsigned CMPW     = (SZW > SizeRegW) ? SZW : SizeRegW;
  localparam int unsigned CW       = SIZE_BITS;
  localparam int unsigned X0W      = (CW > ChanW) ? CW : ChanW;
  localparam int unsigned X1W      = X0W + SZW + 1;
  localparam int unsigned P1W      = X0W + SZW;
  localparam int unsigned P2W      = X1W + SZW;
  localparam int unsigned LoW      = HalfW + SZW;
  localparam int unsigned PosProdW = PosW + LaneW;
  localparam int unsigned KerProdW = KerW + LaneW;
  localparam int unsigned SumW     = PosProdW + 2;

  function automatic logic [SZW-1:0] clamp_size(input logic [SizeRegW-1:0] v);
    logic [CMPW-1:0] top;
    logic [CMPW-1:0] ve;
    top = CMPW'(1) << SIZE_BITS;
    ve  = CMPW'(v);
    if (ve > top) begin
      return SZW'(top);
    end
    return SZW'(ve);
  endfunction

  // configuration registers
  logic            chan_last_q;
  logic [SZW-1:0]  c_size_q, d_size_q, h_size_q, w_size_q;
  logic [SetW-1:0] stride_q, dil_q, pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_last_q <= 1'b0;
      c_size_q    <= SZW'(1);
      d_size_q    <= SZW'(1);
      h_size_q    <= SZW'(1);
      w_size_q    <= SZW'(1);
      stride_q    <= SetW'(24'h010101);
      dil_q       <= SetW'(24'h010101);
      pad_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgChannelsLast: chan_last_q <= cfg_wdata_i[0];
        CfgInChannels:   c_size_q    <= clamp_size(cfg_wdata_i[SizeRegW-1:0]);
        CfgInDepth:      d_size_q    <= clamp_size(cfg_wdata_i[SizeRegW-1:0]);
        CfgInHeight:     h_size_q    <= clamp_size(cfg_wdata_i[SizeRegW-1:0]);
        CfgInWidth:      w_size_q    <= clamp_size(cfg_wdata_i[SizeRegW-1:0]);
        CfgStride:       stride_q    <= cfg_wdata_i;
        CfgDilation:     dil_q       <= cfg_wdata_i;
        CfgPadding:      pad_q       <= cfg_wdata_i;
        default:         chan_last_q <= chan_last_q;
      endcase
    end
  end

  logic [2:0][SZW-1:0] axis_size;
  logic [SZW-1:0]      m2, m3;

  always_comb begin
    axis_size[0] = d_size_q;
    axis_size[1] = h_size_q;
    axis_size[2] = w_size_q;
    m2 = chan_last_q ? w_size_q : h_size_q;
    m3 = chan_last_q ? c_size_q : w_size_q;
  end

  // valid bits
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      done_q     <= s5_valid_q;
    end
  end

  // stage 1: position and kernel products
  logic [2:0][PosW-1:0]     pos;
  logic [2:0][KerW-1:0]     ker;
  logic [2:0][PosProdW-1:0] s1_pos_d, s1_pos_q;
  logic [2:0][KerProdW-1:0] s1_ker_d, s1_ker_q;
  logic [ChanW-1:0]         s1_ch_q;

  always_comb begin
    pos[0] = out_d_i;
    pos[1] = out_h_i;
    pos[2] = out_w_i;
    ker[0] = kernel_d_i;
    ker[1] = kernel_h_i;
    ker[2] = kernel_w_i;
    for (int i = 0; i < 3; i++) begin
      s1_pos_d[i] = pos[i] * stride_q[LaneW*i +: LaneW];
      s1_ker_d[i] = ker[i] * dil_q[LaneW*i +: LaneW];
    end
  end

  // stage 2: coordinates and range check
  logic [2:0][SumW-1:0] coord_sum;
  logic [2:0]           in_range;
  logic [2:0][CW-1:0]   s2_coord_d, s2_coord_q;
  logic                 s2_ok_q;
  logic [ChanW-1:0]     s2_ch_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coord_sum[i] = SumW'(s1_pos_q[i]) + SumW'(s1_ker_q[i])
                   - SumW'(pad_q[LaneW*i +: LaneW]);
      in_range[i]  = !coord_sum[i][SumW-1]
                   && (coord_sum[i][SumW-2:0] < (SumW-1)'(axis_size[i]));
      s2_coord_d[i] = coord_sum[i][CW-1:0];
    end
  end

  // stage 3: first multiply-add of the address
  logic [X0W-1:0] x0, a3_sel;
  logic [SZW-1:0] m1;
  logic [CW-1:0]  a1, a2_sel;
  logic [P1W-1:0] p1;
  logic [X1W-1:0] s3_x_d, s3_x_q;
  logic [CW-1:0]  s3_a2_q;
  logic [X0W-1:0] s3_a3_q;
  logic           s3_ok_q;

  always_comb begin
    x0     = chan_last_q ? X0W'(s2_coord_q[0]) : X0W'(s2_ch_q);
    m1     = chan_last_q ? h_size_q : d_size_q;
    a1     = chan_last_q ? s2_coord_q[1] : s2_coord_q[0];
    a2_sel = chan_last_q ? s2_coord_q[2] : s2_coord_q[1];
    a3_sel = chan_last_q ? X0W'(s2_ch_q) : X0W'(s2_coord_q[2]);
    p1     = x0 * m1;
    s3_x_d = X1W'(p1) + X1W'(a1);
  end

  // stage 4: second multiply-add
  logic [P2W-1:0]   p2;
  logic [AddrW-1:0] s4_x_d, s4_x_q;
  logic [X0W-1:0]   s4_a3_q;
  logic             s4_ok_q;

  always_comb begin
    p2     = s3_x_q * m2;
    s4_x_d = AddrW'(p2) + AddrW'(s3_a2_q);
  end

  // stage 5: last multiply as two half-width partial products
  logic [LoW-1:0]   lo_prod, hi_prod;
  logic [LoW-1:0]   s5_lo_q;
  logic [HalfW-1:0] s5_hi_q;
  logic [X0W-1:0]   s5_a3_q;
  logic             s5_ok_q;

  always_comb begin
    lo_prod = s4_x_q[HalfW-1:0] * m3;
    hi_prod = s4_x_q[AddrW-1:HalfW] * m3;
  end

  // stage 6: combine and gate padding
  logic [AddrW-1:0] addr_sum;
  logic [AddrW-1:0] src_address_q;
  logic             inside_q;

  always_comb begin
    addr_sum = AddrW'(s5_lo_q) + {s5_hi_q, {HalfW{1'b0}}} + AddrW'(s5_a3_q);
  end

  always_ff @(posedge clk_i) begin
    s1_pos_q      <= s1_pos_d;
    s1_ker_q      <= s1_ker_d;
    s1_ch_q       <= channel_i;
    s2_coord_q    <= s2_coord_d;
    s2_ok_q       <= &in_range;
    s2_ch_q       <= s1_ch_q;
    s3_x_q        <= s3_x_d;
    s3_a2_q       <= a2_sel;
    s3_a3_q       <= a3_sel;
    s3_ok_q       <= s2_ok_q;
    s4_x_q        <= s4_x_d;
    s4_a3_q       <= s3_a3_q;
    s4_ok_q       <= s3_ok_q;
    s5_lo_q       <= lo_prod;
    s5_hi_q       <= hi_prod[HalfW-1:0];
    s5_a3_q       <= s4_a3_q;
    s5_ok_q       <= s4_ok_q;
    inside_q      <= s5_ok_q;
    src_address_q <= s5_ok_q ? addr_sum : '0;
  end

  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign inside_res_o  = inside_q;
  assign src_address_o = src_address_q;

endmodule

// ----- rtl/im2col_ag_checker.sv -----
`include "im2col_address_generator_macros.svh"

module im2col_ag_checker
  import im2col_ag_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             done_o,
  input logic             inside_res_o,
  input logic [AddrW-1:0] src_address_o
);

  `IAG_ASSERT_ALWAYS(never_busy_a, !busy_o)
  `IAG_ASSERT_IMP(latency_a, start_i && !busy_o, ##IagLatency done_o)
  `IAG_ASSERT_IMP(done_source_a, done_o, $past(start_i && !busy_o && rst_ni, IagLatency))
  `IAG_ASSERT_IMP(pad_zero_a, done_o && !inside_res_o, src_address_o == '0)

endmodule

bind im2col_address_generator im2col_ag_checker u_im2col_ag_checker (.*);

// ----- tb/sv/im2col_address_generator_tb.sv -----
module im2col_address_generator_tb;
  import im2col_ag_pkg::*;

  localparam int unsigned SizeBits = SizeBitsDefault;
  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned PhaseItems = 150;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [KerW-1:0]  kernel_d;
    logic [KerW-1:0]  kernel_h;
    logic [KerW-1:0]  kernel_w;
    logic [PosW-1:0]  out_d;
    logic [PosW-1:0]  out_h;
    logic [PosW-1:0]  out_w;
  } elem_t;

  localparam int unsigned ElemW = $bits(elem_t);

  typedef struct packed {
    logic             in_vol;
    logic [AddrW-1:0] addr;
  } src_t;

  typedef struct packed {
    logic                chan_last;
    logic [SizeRegW-1:0] channels;
    logic [SizeRegW-1:0] depth;
    logic [SizeRegW-1:0] height;
    logic [SizeRegW-1:0] width;
    logic [SetW-1:0]     stride;
    logic [SetW-1:0]     dilation;
    logic [SetW-1:0]     padding;
  } geom_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgChannelsLast;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                start_i = 1'b0;
  logic [ChanW-1:0]    channel_i = '0;
  logic [KerW-1:0]     kernel_d_i = '0;
  logic [KerW-1:0]     kernel_h_i = '0;
  logic [KerW-1:0]     kernel_w_i = '0;
  logic [PosW-1:0]     out_d_i = '0;
  logic [PosW-1:0]     out_h_i = '0;
  logic [PosW-1:0]     out_w_i = '0;
  logic                busy_o;
  logic                done_o;
  logic                inside_res_o;
  logic [AddrW-1:0]    src_address_o;

  geom_t geom;
  elem_t elem_q[$];
  src_t  src_due_q[$];
  int unsigned n_issued = 0;
  int unsigned n_taken = 0;
  int unsigned idle_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;

  im2col_address_generator #(
    .SIZE_BITS(SizeBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .channel_i    (channel_i),
    .kernel_d_i   (kernel_d_i),
    .kernel_h_i   (kernel_h_i),
    .kernel_w_i   (kernel_w_i),
    .out_d_i      (out_d_i),
    .out_h_i      (out_h_i),
    .out_w_i      (out_w_i),
    .done_o       (done_o),
    .inside_res_o (inside_res_o),
    .src_address_o(src_address_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint clamp_size(logic [SizeRegW-1:0] v);
    longint sz;
    sz = v;
    if (sz > (longint'(1) << SizeBits)) sz = longint'(1) << SizeBits;
    return sz;
  endfunction

  function automatic longint axis_coord(logic [PosW-1:0] pos, logic [KerW-1:0] k,
                                        int unsigned lane);
    longint p, kk, s, dl, pd;
    p = pos;
    kk = k;
    s = geom.stride[LaneW*lane +: LaneW];
    dl = geom.dilation[LaneW*lane +: LaneW];
    pd = geom.padding[LaneW*lane +: LaneW];
    return p * s + kk * dl - pd;
  endfunction

  function automatic src_t compute_source(elem_t e);
    longint cs, ds, hs, ws, d, h, w, ch;
    logic [63:0] flat;
    src_t r;
    cs = clamp_size(geom.channels);
    ds = clamp_size(geom.depth);
    hs = clamp_size(geom.height);
    ws = clamp_size(geom.width);
    ch = e.channel;
    d = axis_coord(e.out_d, e.kernel_d, 0);
    h = axis_coord(e.out_h, e.kernel_h, 1);
    w = axis_coord(e.out_w, e.kernel_w, 2);
    r.in_vol = (d >= 0 && d < ds && h >= 0 && h < hs && w >= 0 && w < ws);
    flat = '0;
    if (r.in_vol) begin
      if (geom.chan_last) flat = ((d * hs + h) * ws + w) * cs + ch;
      else flat = ((ch * ds + d) * hs + h) * ws + w;
    end
    r.addr = flat[AddrW-1:0];
    return r;
  endfunction

  function automatic logic [SetW-1:0] pack3(int unsigned d, int unsigned h, int unsigned w);
    return {w[LaneW-1:0], h[LaneW-1:0], d[LaneW-1:0]};
  endfunction

  function automatic int unsigned near_pos(int unsigned lane, logic [SizeRegW-1:0] size_reg);
    int unsigned s, top;
    s = geom.stride[LaneW*lane +: LaneW];
    if (s == 0) return $urandom_range(7);
    top = int'(clamp_size(size_reg) / s + 2);
    if (top > 4095) top = 4095;
    return $urandom_range(top);
  endfunction

  function automatic elem_t random_elem();
    elem_t e;
    int unsigned ctop;
    e = elem_t'(ElemW'({$urandom, $urandom, $urandom}));
    if ($urandom_range(99) < 75) begin
      ctop = int'(clamp_size(geom.channels));
      ctop = (ctop == 0) ? 3 : ((ctop > 4096) ? 4095 : ctop - 1);
      e.channel = ChanW'($urandom_range(ctop));
      e.kernel_d = KerW'($urandom_range(3));
      e.kernel_h = KerW'($urandom_range(3));
      e.kernel_w = KerW'($urandom_range(3));
      e.out_d = PosW'(near_pos(0, geom.depth));
      e.out_h = PosW'(near_pos(1, geom.height));
      e.out_w = PosW'(near_pos(2, geom.width));
    end
    return e;
  endfunction

  function automatic geom_t random_geom();
    geom_t g;
    g.chan_last = 1'($urandom_range(1));
    g.channels = SizeRegW'($urandom_range(16, 1));
    g.depth = SizeRegW'($urandom_range(12, 1));
    g.height = SizeRegW'($urandom_range(12, 1));
    g.width = SizeRegW'($urandom_range(12, 1));
    g.stride = pack3($urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1));
    g.dilation = pack3($urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1));
    g.padding = pack3($urandom_range(3), $urandom_range(3), $urandom_range(3));
    return g;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_geom(geom_t g);
    write_reg(CfgChannelsLast, CfgDataW'(g.chan_last));
    write_reg(CfgInChannels, CfgDataW'(g.channels));
    write_reg(CfgInDepth, CfgDataW'(g.depth));
    write_reg(CfgInHeight, CfgDataW'(g.height));
    write_reg(CfgInWidth, CfgDataW'(g.width));
    write_reg(CfgStride, g.stride);
    write_reg(CfgDilation, g.dilation);
    write_reg(CfgPadding, g.padding);
    geom = g;
  endtask

  task automatic queue_elem(elem_t e);
    elem_q.push_back(e);
    n_issued++;
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) queue_elem(random_elem());
  endtask

  task automatic drain();
    while (n_taken != n_issued || src_due_q.size() != 0) @(posedge clk_i);
    repeat (IagLatency + 2) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : driver
    elem_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        src_due_q.push_back(compute_source({channel_i, kernel_d_i, kernel_h_i, kernel_w_i,
                                            out_d_i, out_h_i, out_w_i}));
        n_taken++;
      end
      if (!start_i || !busy_o) begin
        if (elem_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = elem_q.pop_front();
          start_i <= 1'b1;
          channel_i <= nxt.channel;
          kernel_d_i <= nxt.kernel_d;
          kernel_h_i <= nxt.kernel_h;
          kernel_w_i <= nxt.kernel_w;
          out_d_i <= nxt.out_d;
          out_h_i <= nxt.out_h;
          out_w_i <= nxt.out_w;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    src_t want;
    if (rst_ni && done_o) begin
      if (src_due_q.size() == 0) begin
        $error("unexpected transfer: inside_res=%0b src_address=%0h",
               inside_res_o, src_address_o);
        n_errors++;
      end else begin
        want = src_due_q.pop_front();
        if (inside_res_o !== want.in_vol) begin
          $error("inside_res: expected %0b, got %0b", want.in_vol, inside_res_o);
          n_errors++;
        end
        if (src_address_o !== want.addr) begin
          $error("src_address: expected %0h, got %0h", want.addr, src_address_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("** im2col_address_generator: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    geom_t g;
    int unsigned idle_levels[4];
    idle_levels = '{0, 85, 21, 0};
    geom = '{chan_last: 1'b0, channels: 1, depth: 1, height: 1, width: 1,
             stride: 24'h010101, dilation: 24'h010101, padding: '0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset registers: a 1x1x1x1 volume
    queue_elem('{12'd4095, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 12'd0});
    queue_elem('{12'd0, 8'd1, 8'd0, 8'd0, 12'd0, 12'd0, 12'd0});
    queue_elem('{12'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 12'd1});
    drain();

    g = '{chan_last: 1'b0, channels: 3, depth: 5, height: 6, width: 7,
          stride: pack3(1, 2, 1), dilation: pack3(1, 1, 2), padding: pack3(1, 2, 0)};
    load_geom(g);
    queue_elem('{12'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 12'd0});
    queue_elem('{12'd0, 8'd1, 8'd2, 8'd0, 12'd0, 12'd0, 12'd0});
    queue_elem('{12'd2, 8'd1, 8'd1, 8'd0, 12'd4, 12'd3, 12'd6});
    queue_elem('{12'd1, 8'd1, 8'd2, 8'd0, 12'd5, 12'd0, 12'd0});
    queue_elem('{12'd1, 8'd1, 8'd0, 8'd0, 12'd0, 12'd4, 12'd0});
    queue_elem('{12'd1, 8'd1, 8'd2, 8'd0, 12'd0, 12'd0, 12'd7});
    queue_elem('{12'd1, 8'd1, 8'd1, 8'd0, 12'd0, 12'd0, 12'd0});
    queue_elem('{12'd4095, 8'd1, 8'd2, 8'd0, 12'd0, 12'd0, 12'd0});
    queue_elem('{12'd4095, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, 12'd4095});
    queue_elem('{12'd0, 8'd0, 8'd2, 8'd3, 12'd1, 12'd0, 12'd0});
    queue_elem('{12'd3, 8'd2, 8'd3, 8'd1, 12'd2, 12'd1, 12'd4});
    queue_random(PhaseItems);
    drain();

    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: g.chan_last = 1'b1;
        2, 3: begin
          g = '{chan_last: (p == 3), channels: 4096, depth: 4096, height: 4096, width: 4096,
                stride: 24'h010101, dilation: 24'h010101, padding: '0};
        end
        4: begin
          g = '{chan_last: 1'($urandom_range(1)), channels: 8191, depth: 8191, height: 8191,
                width: 8191, stride: 24'hFFFFFF, dilation: 24'hFFFFFF, padding: 24'hFFFFFF};
        end
        5: begin
          g = random_geom();
          g.height = 0;
        end
        6: begin
          g = random_geom();
          g.channels = 0;
          g.stride = '0;
        end
        7: begin
          g = random_geom();
          g.dilation = '0;
        end
        default: g = random_geom();
      endcase
      load_geom(g);
      idle_pct = idle_levels[p % 4];
      queue_random(PhaseItems);
      drain();
    end

    repeat (IagLatency + 4) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("** im2col_address_generator: PASSED **");
    end else begin
      $display("** im2col_address_generator: FAILED **");
    end
    $finish;
  end

endmodule
